### rtl/core/ifr_pkg.sv
// Shared constants, types and helpers of the integer radix formatter.
`timescale 1ns / 1ps
package ifr_pkg;

   localparam int DEF_VALUE_BITS = 64;
   localparam int DEF_MAX_CHARS  = 64;

   localparam int VALUE_FIELD_BITS = 64;
   localparam int SMALL_FIELD_BITS = 6;
   localparam int FLAG_BITS        = 7;
   localparam int REQ_DATA_BITS    = 96;
   localparam int CHAR_BITS        = 8;
   localparam int DIGIT_BITS       = 6;
   localparam int LEN_BITS         = 8;
   localparam int STEP_BITS        = 8;

   localparam int BASE_LSB  = VALUE_FIELD_BITS;
   localparam int WIDTH_LSB = BASE_LSB + SMALL_FIELD_BITS;
   localparam int PREC_LSB  = WIDTH_LSB + SMALL_FIELD_BITS;
   localparam int FLAGS_LSB = PREC_LSB + SMALL_FIELD_BITS;

   localparam int FL_LEFT   = 0;
   localparam int FL_ZERO   = 1;
   localparam int FL_SIGNED = 2;
   localparam int FL_PLUS   = 3;
   localparam int FL_SPACE  = 4;
   localparam int FL_PREFIX = 5;
   localparam int FL_LOWER  = 6;

   localparam logic [SMALL_FIELD_BITS-1:0] BASE_MIN = 6'd2;
   localparam logic [SMALL_FIELD_BITS-1:0] BASE_MAX = 6'd36;
   localparam logic [SMALL_FIELD_BITS-1:0] BASE_OCT = 6'd8;
   localparam logic [SMALL_FIELD_BITS-1:0] BASE_HEX = 6'd16;

   localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_UP_X  = 8'h58;
   localparam logic [CHAR_BITS-1:0] CH_LO_X  = 8'h78;
   localparam logic [CHAR_BITS-1:0] CH_UP_A_OFS = 8'h37;
   localparam logic [CHAR_BITS-1:0] CH_LO_A_OFS = 8'h57;

   typedef struct packed {
      logic push;
      logic pop;
   } ifr_stack_ctl_type;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d,
                                                      input logic lower);
      logic [CHAR_BITS-1:0] ext;
      ext = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
      if (d < 6'd10) begin
         digit_char = CH_ZERO + ext;
      end else if (lower) begin
         digit_char = CH_LO_A_OFS + ext;
      end else begin
         digit_char = CH_UP_A_OFS + ext;
      end
   endfunction

endpackage

### rtl/core/ifr_divider.sv
// Iterative divider: value by radix, eight quotient bits per cycle.
`timescale 1ns / 1ps
module ifr_divider
   import ifr_pkg::*;
#(
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [DIGIT_BITS-1:0] divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [DIGIT_BITS-1:0] remainder
);

   localparam int STEPS    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS = STEPS * STEP_BITS;
   localparam int CNT_BITS = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(STEPS - 1);

   logic [PAD_BITS-1:0]   work_ff, work_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic                  run_ff;
   logic                  done_ff;

   always_comb begin
      logic [PAD_BITS-1:0]   w;
      logic [DIGIT_BITS-1:0] r;
      logic [DIGIT_BITS:0]   part;
      w = work_ff;
      r = rem_ff;
      for (int k = 0; k < STEP_BITS; k++) begin
         part = {r, w[PAD_BITS-1]};
         w    = {w[PAD_BITS-2:0], 1'b0};
         if (part >= {1'b0, divisor}) begin
            part = part - {1'b0, divisor};
            w[0] = 1'b1;
         end
         r = part[DIGIT_BITS-1:0];
      end
      work_in = w;
      rem_in  = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CNT_LAST);
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (cnt_ff == CNT_LAST)) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= PAD_BITS'(dividend);
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else if (run_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   assign done      = done_ff;
   assign quotient  = work_ff[VALUE_BITS-1:0];
   assign remainder = rem_ff;

endmodule

### rtl/core/ifr_digit_stack.sv
// Shift-register stack of digits: push at the top, pop from the top.
`timescale 1ns / 1ps
module ifr_digit_stack
   import ifr_pkg::*;
#(
   parameter int DEPTH = DEF_VALUE_BITS
) (
   input  logic                  clock,
   input  ifr_stack_ctl_type     ctl,
   input  logic [DIGIT_BITS-1:0] push_digit,
   output logic [DIGIT_BITS-1:0] top_digit
);

   logic [DIGIT_BITS-1:0] entry_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entry_ff[0] <= push_digit;
         for (int k = 1; k < DEPTH; k++) begin
            entry_ff[k] <= entry_ff[k-1];
         end
      end else if (ctl.pop) begin
         for (int k = 0; k < DEPTH - 1; k++) begin
            entry_ff[k] <= entry_ff[k+1];
         end
      end
   end

   assign top_digit = entry_ff[0];

endmodule

### rtl/core/integer_radix_formatter.sv
// Top level: printf-style integer to ASCII formatter, one character per item.
//
//   channel  direction  fields (lowest bit first)
//   req_     in         tdata: value, base, width, precision, format_flags
//   rsp_     out        tdata: text_char; tlast: last_char; tuser: bad_base
//
// Each number passes S_PREP, one division per digit in the shared divider
// (none for a zero value), the layout states S_SIZE, S_PAD and S_BOUND,
// then one character per cycle while rsp_tready stays high. Reset clears
// the sequencer and the output valid; req_tready is high only when idle.
// A stalled output holds its character and the sequencer in S_EMIT or S_BAD.
`timescale 1ns / 1ps
module integer_radix_formatter
   import ifr_pkg::*;
#(
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   parameter int MAX_CHARS  = DEF_MAX_CHARS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // value[63:0], base[69:64], width[75:70], precision[81:76],
   // format_flags[88:82], zero[95:89]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // text_char[7:0]
   output logic [CHAR_BITS-1:0]     rsp_tdata,
   output logic                     rsp_tlast,
   // bad_base[0]
   output logic                     rsp_tuser
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_DIV,
      S_SIZE,
      S_PAD,
      S_BOUND,
      S_EMIT,
      S_BAD
   } state_type;

   state_type                   state_ff;
   logic [VALUE_BITS-1:0]       value_ff;
   logic [SMALL_FIELD_BITS-1:0] base_ff;
   logic [SMALL_FIELD_BITS-1:0] width_ff;
   logic [SMALL_FIELD_BITS-1:0] prec_ff;
   logic [FLAG_BITS-1:0]        flags_ff;
   logic [CHAR_BITS-1:0]        sign_ch_ff;
   logic                        sign_len_ff;
   logic [LEN_BITS-1:0]         nd_ff;
   logic [LEN_BITS-1:0]         effprec_ff;
   logic [LEN_BITS-1:0]         pad_ff;
   logic [LEN_BITS-1:0]         b0_ff, b1_ff, b2_ff, b4_ff, b5_ff;
   logic [LEN_BITS-1:0]         last_idx_ff;
   logic [LEN_BITS-1:0]         idx_ff;
   logic                        rsp_tvalid_ff;
   logic [CHAR_BITS-1:0]        rsp_tdata_ff;
   logic                        rsp_tlast_ff;
   logic                        rsp_tuser_ff;

   logic                        base_bad;
   logic                        value_zero;
   logic                        negative;
   logic [VALUE_BITS-1:0]       magnitude;
   logic [1:0]                  pfx_len;
   logic                        left_mode, zero_mode, space_mode;
   logic                        out_free;
   logic                        rsp_load;
   logic                        div_start;
   logic [VALUE_BITS-1:0]       div_dividend;
   logic                        div_done;
   logic [VALUE_BITS-1:0]       div_quotient;
   logic [DIGIT_BITS-1:0]       div_remainder;
   ifr_stack_ctl_type           stack_ctl;
   logic [DIGIT_BITS-1:0]       push_digit;
   logic [DIGIT_BITS-1:0]       top_digit;
   logic [LEN_BITS-1:0]         need_len;
   logic [LEN_BITS-1:0]         width_ext;
   logic [LEN_BITS-1:0]         prec_ext;
   logic [LEN_BITS-1:0]         lpad, zpad, rpad;
   logic [LEN_BITS-1:0]         b2_val, total_len, limit_len;
   logic [CHAR_BITS-1:0]        emit_ch;
   logic                        in_digits;

   always_comb begin
      base_bad   = !(req_tdata[BASE_LSB +: SMALL_FIELD_BITS] inside {[BASE_MIN:BASE_MAX]});
      value_zero = (value_ff == '0);
      negative   = flags_ff[FL_SIGNED] && value_ff[VALUE_BITS-1];
      magnitude  = negative ? (~value_ff + 1'b1) : value_ff;
      left_mode  = flags_ff[FL_LEFT];
      zero_mode  = flags_ff[FL_ZERO] && !flags_ff[FL_LEFT];
      space_mode = !flags_ff[FL_ZERO] && !flags_ff[FL_LEFT];
      if (flags_ff[FL_PREFIX] && (base_ff == BASE_HEX)) begin
         pfx_len = 2'd2;
      end else if (flags_ff[FL_PREFIX] && (base_ff == BASE_OCT)) begin
         pfx_len = 2'd1;
      end else begin
         pfx_len = 2'd0;
      end
      out_free = !rsp_tvalid_ff || rsp_tready;
      rsp_load = out_free && ((state_ff == S_EMIT) || (state_ff == S_BAD));

      div_start    = ((state_ff == S_PREP) && !value_zero) ||
                     ((state_ff == S_DIV) && div_done && (div_quotient != '0));
      div_dividend = (state_ff == S_PREP) ? magnitude : div_quotient;

      stack_ctl.push = ((state_ff == S_PREP) && value_zero) ||
                       ((state_ff == S_DIV) && div_done);
      push_digit     = (state_ff == S_PREP) ? '0 : div_remainder;

      in_digits     = (idx_ff >= b4_ff) && (idx_ff < b5_ff);
      stack_ctl.pop = (state_ff == S_EMIT) && out_free && in_digits;

      width_ext = LEN_BITS'(width_ff);
      prec_ext  = LEN_BITS'(prec_ff);
      need_len  = LEN_BITS'(sign_len_ff) + LEN_BITS'(pfx_len) + effprec_ff;
      lpad      = space_mode ? pad_ff : '0;
      zpad      = zero_mode ? pad_ff : '0;
      rpad      = left_mode ? pad_ff : '0;
      b2_val    = lpad + LEN_BITS'(sign_len_ff) + LEN_BITS'(pfx_len);
      total_len = b2_val + zpad + effprec_ff + rpad;
      limit_len = (total_len < LEN_BITS'(MAX_CHARS)) ? total_len : LEN_BITS'(MAX_CHARS);

      if (idx_ff < b0_ff) begin
         emit_ch = CH_SPACE;
      end else if (idx_ff < b1_ff) begin
         emit_ch = sign_ch_ff;
      end else if (idx_ff < b2_ff) begin
         if (idx_ff == b1_ff) begin
            emit_ch = CH_ZERO;
         end else begin
            emit_ch = flags_ff[FL_LOWER] ? CH_LO_X : CH_UP_X;
         end
      end else if (idx_ff < b4_ff) begin
         emit_ch = CH_ZERO;
      end else if (in_digits) begin
         emit_ch = digit_char(top_digit, flags_ff[FL_LOWER]);
      end else begin
         emit_ch = CH_SPACE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  value_ff <= req_tdata[VALUE_BITS-1:0];
                  base_ff  <= req_tdata[BASE_LSB +: SMALL_FIELD_BITS];
                  width_ff <= req_tdata[WIDTH_LSB +: SMALL_FIELD_BITS];
                  prec_ff  <= req_tdata[PREC_LSB +: SMALL_FIELD_BITS];
                  flags_ff <= req_tdata[FLAGS_LSB +: FLAG_BITS];
                  state_ff <= base_bad ? S_BAD : S_PREP;
               end
            end
            S_PREP: begin
               if (negative) begin
                  sign_ch_ff  <= CH_MINUS;
                  sign_len_ff <= 1'b1;
               end else if (flags_ff[FL_PLUS]) begin
                  sign_ch_ff  <= CH_PLUS;
                  sign_len_ff <= 1'b1;
               end else if (flags_ff[FL_SPACE]) begin
                  sign_ch_ff  <= CH_SPACE;
                  sign_len_ff <= 1'b1;
               end else begin
                  sign_ch_ff  <= CH_NUL;
                  sign_len_ff <= 1'b0;
               end
               if (value_zero) begin
                  nd_ff    <= LEN_BITS'(1);
                  state_ff <= S_SIZE;
               end else begin
                  nd_ff    <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  nd_ff <= nd_ff + 1'b1;
                  if (div_quotient == '0) begin
                     state_ff <= S_SIZE;
                  end
               end
            end
            S_SIZE: begin
               effprec_ff <= (nd_ff > prec_ext) ? nd_ff : prec_ext;
               state_ff   <= S_PAD;
            end
            S_PAD: begin
               pad_ff   <= (width_ext > need_len) ? (width_ext - need_len) : '0;
               state_ff <= S_BOUND;
            end
            S_BOUND: begin
               b0_ff       <= lpad;
               b1_ff       <= lpad + LEN_BITS'(sign_len_ff);
               b2_ff       <= b2_val;
               b4_ff       <= b2_val + zpad + effprec_ff - nd_ff;
               b5_ff       <= b2_val + zpad + effprec_ff;
               last_idx_ff <= limit_len - 1'b1;
               idx_ff      <= '0;
               state_ff    <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_tdata_ff  <= emit_ch;
                  rsp_tlast_ff  <= (idx_ff == last_idx_ff);
                  rsp_tuser_ff  <= 1'b0;
                  idx_ff        <= idx_ff + 1'b1;
                  if (idx_ff == last_idx_ff) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_BAD: begin
               if (out_free) begin
                  rsp_tdata_ff  <= CH_NUL;
                  rsp_tlast_ff  <= 1'b1;
                  rsp_tuser_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   ifr_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (base_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   ifr_digit_stack #(
      .DEPTH (VALUE_BITS)
   ) u_digit_stack (
      .clock      (clock),
      .ctl        (stack_ctl),
      .push_digit (push_digit),
      .top_digit  (top_digit)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
